/* rtl/fisher_yates_shuffle_engine_macros.svh */
// Assertion macros for the shuffle engine.
// Included by the RTL files that carry concurrent checks; clk_i and rst_ni must be in scope.
`ifndef FISHER_YATES_SHUFFLE_ENGINE_MACROS_SVH
`define FISHER_YATES_SHUFFLE_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define FYSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define FYSE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FYSE_ASSERT(lbl, prop, msg)
`define FYSE_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/fyse_pkg.sv */
// Shared constants, payload structs and controller/datapath signal groups.
// Used by the controller, datapath and top level of the shuffle engine; depends on nothing.
package fyse_pkg;

  localparam int unsigned STORE_DEPTH  = 512;
  localparam int unsigned ELEMENT_BITS = 16;
  localparam int unsigned IDX_W        = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W        = $clog2(STORE_DEPTH + 1);
  localparam int unsigned STEP_W       = (CNT_W > 6) ? CNT_W : 6;

  // Fixed field widths of the ports.
  localparam int unsigned ACTION_BITS = 2;
  localparam int unsigned INDEX_BITS  = 9;
  localparam int unsigned VALUE_BITS  = 16;
  localparam int unsigned COUNT_BITS  = 10;
  localparam int unsigned CMP_W       = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(52);

  // Generator constants.
  localparam logic [63:0] WY_ADD = 64'ha0761d6478bd642f;
  localparam logic [63:0] WY_XOR = 64'he7037ed1a0b428db;
  localparam int unsigned MUL_STEPS = 4;
  localparam int unsigned MOD_STEPS = 64;

  // Action codes.
  localparam logic [ACTION_BITS-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_REFRESH = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_SHUFFLE = 2'd2;
  localparam logic [ACTION_BITS-1:0] ACT_READ    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'd1;

  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [INDEX_BITS-1:0]  index;
    logic [VALUE_BITS-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] read_value;
    logic                  out_of_range;
  } out_item_t;

  typedef struct packed {
    logic              capture;
    logic              load_wr;
    logic              read_rd;
    logic              copy_en;
    logic [STEP_W-1:0] step;
    logic              shuf_init;
    logic              gen_add;
    logic              mul_en;
    logic              draw_mul;
    logic              mod_init;
    logic              mod_en;
    logic              rd_i;
    logic              rd_j;
    logic              wr_i;
    logic              wr_j;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    logic count_gt1;
    logic i_is_one;
    logic lo_ge_bound;
    logic lim_valid;
    logic lo_ge_lim;
  } status_t;

endpackage

/* rtl/fyse_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module fyse_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/fyse_datapath.sv */
// Datapath: stores, generator, split multiplier, limit remainder unit and result register.
// Depends on fyse_pkg and fyse_ram.
module fyse_datapath
  import fyse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  in_item_t              in_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [63:0]           cfg_data_i,
  output logic                  done_o,
  output out_item_t             out_item_o
);

  logic [COUNT_BITS-1:0] count_q;
  logic [63:0]           gstate_q;
  in_item_t              item_q;
  logic [IDX_W-1:0]      i_q, j_q;
  logic [63:0]           a_q, b_q, lo_q;
  logic [127:0]          acc_q;
  logic [CNT_W-1:0]      rem_q;
  logic                  lim_valid_q;
  logic [ELEMENT_BITS-1:0] ti_q;
  logic                  done_q;
  out_item_t             out_q;

  logic [CNT_W-1:0]      count_eff;
  logic                  in_range;
  logic [CNT_W-1:0]      bound;

  // Effective count is the register limited to the store depth.
  always_comb begin
    if (CMP_W'(count_q) > CMP_W'(STORE_DEPTH)) begin
      count_eff = CNT_W'(STORE_DEPTH);
    end else begin
      count_eff = CNT_W'(count_q);
    end
  end

  assign in_range = CMP_W'(item_q.index) < CMP_W'(count_eff);
  assign bound    = CNT_W'(i_q) + CNT_W'(1);

  // Configuration registers and generator state.
  logic [63:0] gen_sum;
  assign gen_sum = gstate_q + WY_ADD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= COUNT_RESET;
      gstate_q <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_SEED) begin
        gstate_q <= cfg_data_i;
      end else if (cmd_i.gen_add) begin
        gstate_q <= gen_sum;
      end
      if (cfg_we_i && cfg_index_i == CFG_COUNT) begin
        count_q <= cfg_data_i[COUNT_BITS-1:0];
      end
    end
  end

  // Multiplier: one 32 by 32 partial product per step into the accumulator.
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  pp;
  logic [127:0] pp_shifted;
  always_comb begin
    mul_a = cmd_i.step[0] ? a_q[63:32] : a_q[31:0];
    mul_b = cmd_i.step[1] ? b_q[63:32] : b_q[31:0];
    pp    = 64'(mul_a) * 64'(mul_b);
    unique case (cmd_i.step[1:0])
      2'd0:    pp_shifted = {64'd0, pp};
      2'd3:    pp_shifted = {pp, 64'd0};
      default: pp_shifted = {32'd0, pp, 32'd0};
    endcase
  end

  // Bounded draw: random word times bound.
  logic [63:0]       rnd;
  logic [64+CNT_W-1:0] draw_prod;
  assign rnd       = acc_q[127:64] ^ acc_q[63:0];
  assign draw_prod = (64+CNT_W)'(rnd) * (64+CNT_W)'(bound);

  // Remainder step of two to the 64 modulo the bound.
  logic [CNT_W:0] rem_dbl;
  logic [CNT_W:0] rem_next;
  always_comb begin
    rem_dbl = {rem_q, 1'b0};
    if (rem_dbl >= (CNT_W+1)'(bound)) begin
      rem_next = rem_dbl - (CNT_W+1)'(bound);
    end else begin
      rem_next = rem_dbl;
    end
  end

  // Draw and limit registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (cmd_i.gen_add) begin
      a_q   <= gen_sum;
      b_q   <= gen_sum ^ WY_XOR;
      acc_q <= '0;
    end else if (cmd_i.mul_en) begin
      acc_q <= acc_q + pp_shifted;
    end
    if (cmd_i.draw_mul) begin
      j_q  <= draw_prod[64 +: IDX_W];
      lo_q <= draw_prod[63:0];
    end
    if (cmd_i.mod_init) begin
      rem_q <= CNT_W'(1);
    end else if (cmd_i.mod_en) begin
      rem_q <= rem_next[CNT_W-1:0];
    end
    if (cmd_i.shuf_init) begin
      i_q <= IDX_W'(count_eff - CNT_W'(1));
    end else if (cmd_i.wr_j) begin
      i_q <= i_q - IDX_W'(1);
    end
  end

  // Limit validity and result strobe are control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (cmd_i.shuf_init || cmd_i.wr_j) begin
        lim_valid_q <= 1'b0;
      end else if (cmd_i.mod_init) begin
        lim_valid_q <= 1'b1;
      end
      done_q <= cmd_i.finish;
    end
  end

  // Stores.
  logic                    orig_we, work_we;
  logic [IDX_W-1:0]        orig_raddr, work_raddr, work_waddr;
  logic [ELEMENT_BITS-1:0] orig_rdata, work_rdata, work_wdata;

  assign orig_we    = cmd_i.load_wr && in_range;
  assign orig_raddr = cmd_i.step[IDX_W-1:0];

  always_comb begin
    work_we    = 1'b0;
    work_waddr = i_q;
    work_wdata = work_rdata;
    if (cmd_i.copy_en && cmd_i.step != '0) begin
      work_we    = 1'b1;
      work_waddr = IDX_W'(cmd_i.step - STEP_W'(1));
      work_wdata = orig_rdata;
    end else if (cmd_i.wr_i) begin
      work_we = 1'b1;
    end else if (cmd_i.wr_j) begin
      work_we    = 1'b1;
      work_waddr = j_q;
      work_wdata = ti_q;
    end
    if (cmd_i.rd_j) begin
      work_raddr = j_q;
    end else if (cmd_i.rd_i) begin
      work_raddr = i_q;
    end else begin
      work_raddr = IDX_W'(item_q.index);
    end
  end

  fyse_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(STORE_DEPTH)) u_orig_ram (
    .clk_i   (clk_i),
    .we_i    (orig_we),
    .waddr_i (IDX_W'(item_q.index)),
    .wdata_i (ELEMENT_BITS'(item_q.value)),
    .raddr_i (orig_raddr),
    .rdata_o (orig_rdata)
  );

  fyse_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(STORE_DEPTH)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (work_we),
    .waddr_i (work_waddr),
    .wdata_i (work_wdata),
    .raddr_i (work_raddr),
    .rdata_o (work_rdata)
  );

  // Hold the element at the upper swap position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_j) begin
      ti_q <= work_rdata;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (item_q.action == ACT_READ && in_range) begin
        out_q.read_value <= VALUE_BITS'(work_rdata);
      end else begin
        out_q.read_value <= '0;
      end
      out_q.out_of_range <= (item_q.action == ACT_LOAD || item_q.action == ACT_READ)
                            && !in_range;
    end
  end

  assign status_o.count_gt1   = count_eff > CNT_W'(1);
  assign status_o.i_is_one    = i_q == IDX_W'(1);
  assign status_o.lo_ge_bound = lo_q >= 64'(bound);
  assign status_o.lim_valid   = lim_valid_q;
  assign status_o.lo_ge_lim   = lo_q >= 64'(rem_q);
  assign done_o     = done_q;
  assign out_item_o = out_q;

endmodule

/* rtl/fyse_ctrl.sv */
// Controller state machine: sequences load, read, copy sweep and the shuffle pass.
// Depends on fyse_pkg.
module fyse_ctrl
  import fyse_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic [ACTION_BITS-1:0] action_i,
  input  status_t                status_i,
  output cmd_t                   cmd_o,
  output logic                   busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_DONE  = 4'd3;
  localparam logic [3:0] S_COPY  = 4'd4;
  localparam logic [3:0] S_SINIT = 4'd5;
  localparam logic [3:0] S_GEN   = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_DRAW  = 4'd8;
  localparam logic [3:0] S_CHECK = 4'd9;
  localparam logic [3:0] S_MODI  = 4'd10;
  localparam logic [3:0] S_MOD   = 4'd11;
  localparam logic [3:0] S_RDI   = 4'd12;
  localparam logic [3:0] S_RDJ   = 4'd13;
  localparam logic [3:0] S_WRI   = 4'd14;
  localparam logic [3:0] S_WRJ   = 4'd15;

  logic [3:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  assign busy = state_q != S_IDLE;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    cmd_o.step = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          step_d        = '0;
          unique case (action_i)
            ACT_LOAD:    state_d = S_LOAD;
            ACT_REFRESH: state_d = S_COPY;
            ACT_SHUFFLE: state_d = S_SINIT;
            default:     state_d = S_READ;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load_wr = 1'b1;
        cmd_o.finish  = 1'b1;
        state_d       = S_IDLE;
      end
      S_READ: begin
        cmd_o.read_rd = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      S_COPY: begin
        cmd_o.copy_en = 1'b1;
        if (step_q == STEP_W'(STORE_DEPTH)) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_SINIT: begin
        cmd_o.shuf_init = 1'b1;
        if (status_i.count_gt1) begin
          state_d = S_GEN;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_GEN: begin
        cmd_o.gen_add = 1'b1;
        step_d        = '0;
        state_d       = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (step_q == STEP_W'(MUL_STEPS - 1)) begin
          state_d = S_DRAW;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_DRAW: begin
        cmd_o.draw_mul = 1'b1;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        priority if (status_i.lo_ge_bound || (status_i.lim_valid && status_i.lo_ge_lim)) begin
          state_d = S_RDI;
        end else if (!status_i.lim_valid) begin
          state_d = S_MODI;
        end else begin
          state_d = S_GEN;
        end
      end
      S_MODI: begin
        cmd_o.mod_init = 1'b1;
        step_d         = '0;
        state_d        = S_MOD;
      end
      S_MOD: begin
        cmd_o.mod_en = 1'b1;
        if (step_q == STEP_W'(MOD_STEPS - 1)) begin
          state_d = S_CHECK;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_RDI: begin
        cmd_o.rd_i = 1'b1;
        state_d    = S_RDJ;
      end
      S_RDJ: begin
        cmd_o.rd_j = 1'b1;
        state_d    = S_WRI;
      end
      S_WRI: begin
        cmd_o.wr_i = 1'b1;
        state_d    = S_WRJ;
      end
      default: begin
        cmd_o.wr_j = 1'b1;
        if (status_i.i_is_one) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_GEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

/* rtl/fisher_yates_shuffle_engine.sv */
// Top level of the shuffle engine: controller, datapath and configuration port.
// Depends on fyse_pkg, fyse_ctrl, fyse_datapath and the assertion macro header.
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+----------------------------------
//   item in  | start, busy             | in_item_i (action, index, value)
//   result   | done_o (one-cycle beat) | out_item_o (read_value, out_of_range)
//   config   | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_data_i
//
// Load is busy in S_LOAD and read in S_READ and S_DONE; each result beat follows in the cycle after.
// Refresh sweeps the store through the single read port.
// Shuffle runs one setup state, then per position a generator step, the 4-step multiplier, the draw,
// a check and the swap reads and writes; a rejected draw goes back to the generator step, and the
// rejection limit is reckoned by the remainder unit when it is first needed for a position.
// Reset loads the generator with seed 0 and count 52; stores are not cleared.
// The result beat cannot be stalled; a new item may start while it is shown.
`include "fisher_yates_shuffle_engine_macros.svh"
module fisher_yates_shuffle_engine
  import fyse_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item_i,
  output logic                 done_o,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // Configuration beats are taken whenever no item is in work.
  assign cfg_ready_o = !busy;

  fyse_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (in_item_i.action),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  fyse_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .out_item_o  (out_item_o)
  );

  // Checks on the control flow.
  `FYSE_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not start work")
  `FYSE_ASSERT(a_done_after_busy, done_o |-> $past(busy), "result beat without work")
  `FYSE_NEVER(a_oor_zero, done_o && out_item_o.out_of_range && out_item_o.read_value != '0, "out of range with data")

endmodule
